// ===== rtl/ptlik_pkg.sv =====
// Shared types, constants and table functions for the planar three-link IK core.
package ptlik_pkg;

  // Field widths fixed by the interface.
  localparam int CoordW = 16;
  localparam int PitchW = 15;
  localparam int LenW   = 15;
  localparam int AngW   = 14;

  // Rotation CORDIC unit vector is scaled by 2^30; the start value holds the gain.
  localparam int CosW = 33;
  localparam int UnitShift = 30;
  localparam logic signed [CosW-1:0] CordicStart = 33'sd652032874;

  // Angles in 1/64 degree.
  localparam int QuarterTurn = 5760;
  localparam int HalfTurn    = 11520;
  localparam int FullTurn    = 23040;

  // Vectoring CORDIC widths: inputs, normalised operands and working registers.
  localparam int VinW  = 34;
  localparam int NormW = 42;
  localparam int VecW  = 45;

  // Square root unit: 62-bit radicand, one result bit per stage.
  localparam int SqrtInW  = 62;
  localparam int SqrtOutW = 32;
  localparam int SqrtSteps = 32;

  // Arctangent table, atan(2^-i) in 1/64 degree scaled by 2^16.
  localparam int TableFrac = 16;
  localparam logic [31:0] AtanTab [32] = '{
    32'd188743680, 32'd111421900, 32'd58872272, 32'd29884485, 32'd15000234,
    32'd7507429, 32'd3754631, 32'd1877430, 32'd938729, 32'd469366,
    32'd234683, 32'd117342, 32'd58671, 32'd29335, 32'd14668, 32'd7334,
    32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229, 32'd115, 32'd57, 32'd29,
    32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0, 32'd0, 32'd0
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegUpper = 2'd0,
    RegFore  = 2'd1,
    RegTool  = 2'd2
  } reg_idx_e;

  // One classified request as held in the queue between front and back.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [PitchW-1:0] p;
    logic signed [AngW-1:0]   ang;
    logic                     neg;
  } req_t;

  // Arctangent step truncated to the accumulator's fraction bits.
  function automatic logic [31:0] atan_step(int i, int fb);
    return AtanTab[i] >> (TableFrac - fb);
  endfunction

endpackage

// ===== rtl/ptlik_front.sv =====
// Front end: accepts requests, folds the pitch into the rotation range and queues them.
module ptlik_front import ptlik_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] target_x_i,
  input  logic signed [CoordW-1:0] target_y_i,
  input  logic signed [PitchW-1:0] pitch_i,
  output logic                     busy_o,
  output logic                     req_valid_o,
  output req_t                     req_o
);

  localparam int Depth = 2;

  req_t        fifo_q [Depth];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;
  logic        push, pop;
  logic signed [15:0] wrap, fold;
  logic        neg;
  req_t        entry;

  // Reduce the pitch to one turn, then fold it into +-90 degrees with a sign flag.
  always_comb begin
    wrap = 16'(pitch_i);
    if (wrap >= 16'(HalfTurn)) begin
      wrap = wrap - 16'(FullTurn);
    end else if (wrap < -16'(HalfTurn)) begin
      wrap = wrap + 16'(FullTurn);
    end
    fold = wrap;
    neg  = 1'b0;
    if (wrap > 16'(QuarterTurn)) begin
      fold = wrap - 16'(HalfTurn);
      neg  = 1'b1;
    end else if (wrap < -16'(QuarterTurn)) begin
      fold = wrap + 16'(HalfTurn);
      neg  = 1'b1;
    end
    entry.x   = target_x_i;
    entry.y   = target_y_i;
    entry.p   = pitch_i;
    entry.ang = AngW'(fold);
    entry.neg = neg;
  end

  // The back end takes a request in every cycle that one is queued.
  assign busy_o      = (count_q == 2'(Depth));
  assign push        = start_i && !busy_o;
  assign pop         = (count_q != 2'd0);
  assign req_valid_o = pop;
  assign req_o       = fifo_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== rtl/ptlik_rot.sv =====
// Pipelined rotation CORDIC giving the cosine and sine of the folded pitch.
module ptlik_rot import ptlik_pkg::*; #(
  parameter int Steps    = 16,
  parameter int FracBits = 8,
  parameter int TagW     = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [AngW-1:0] ang_i,
  input  logic                   neg_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic signed [CosW-1:0] cos_o,
  output logic signed [CosW-1:0] sin_o,
  output logic [TagW-1:0]        tag_o
);

  localparam int ZW = 16 + FracBits;

  logic                   valid_q [Steps+1];
  logic signed [CosW-1:0] x_q     [Steps+1];
  logic signed [CosW-1:0] y_q     [Steps+1];
  logic signed [ZW-1:0]   z_q     [Steps+1];
  logic                   neg_q   [Steps+1];
  logic [TagW-1:0]        tag_q   [Steps+1];

  // Entry stage loads the unit vector and the angle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= CordicStart;
    y_q[0]   <= '0;
    z_q[0]   <= ZW'(ang_i) <<< FracBits;
    neg_q[0] <= neg_i;
    tag_q[0] <= tag_i;
  end

  // One micro-rotation per stage, steered by the sign of the residual angle.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [ZW-1:0] Step = ZW'(atan_step(i, FracBits));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!z_q[i][ZW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - Step;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + Step;
      end
      neg_q[i+1] <= neg_q[i];
      tag_q[i+1] <= tag_q[i];
    end
  end

  // Undo the half-turn fold.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    cos_o <= neg_q[Steps] ? -x_q[Steps] : x_q[Steps];
    sin_o <= neg_q[Steps] ? -y_q[Steps] : y_q[Steps];
    tag_o <= tag_q[Steps];
  end

endmodule

// ===== rtl/ptlik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ptlik_isqrt import ptlik_pkg::*; #(
  parameter int TagW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [SqrtInW-1:0]  rad_i,
  input  logic [TagW-1:0]     tag_i,
  output logic                valid_o,
  output logic [SqrtOutW-1:0] root_o,
  output logic [TagW-1:0]     tag_o
);

  logic               valid_q [SqrtSteps+1];
  logic [SqrtInW-1:0] v_q     [SqrtSteps+1];
  logic [63:0]        r_q     [SqrtSteps+1];
  logic [TagW-1:0]    tag_q   [SqrtSteps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q[0]   <= rad_i;
    r_q[0]   <= '0;
    tag_q[0] <= tag_i;
  end

  // Each stage tries the next bit pair of the radicand.
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_bit
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        fits;

    assign trial = r_q[k] + Bit;
    assign fits  = ({2'b00, v_q[k]} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (fits) begin
        v_q[k+1] <= v_q[k] - SqrtInW'(trial);
        r_q[k+1] <= (r_q[k] >> 1) + Bit;
      end else begin
        v_q[k+1] <= v_q[k];
        r_q[k+1] <= r_q[k] >> 1;
      end
      tag_q[k+1] <= tag_q[k];
    end
  end

  assign valid_o = valid_q[SqrtSteps];
  assign root_o  = r_q[SqrtSteps][SqrtOutW-1:0];
  assign tag_o   = tag_q[SqrtSteps];

endmodule

// ===== rtl/ptlik_vec.sv =====
// Pipelined vectoring CORDIC: normalises the vector, then accumulates atan2(y, x).
module ptlik_vec import ptlik_pkg::*; #(
  parameter int Steps    = 16,
  parameter int FracBits = 8,
  parameter int TagW     = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [VinW-1:0]       x_i,
  input  logic signed [VinW-1:0]       y_i,
  input  logic [TagW-1:0]              tag_i,
  output logic                         valid_o,
  output logic signed [16+FracBits-1:0] ang_o,
  output logic [TagW-1:0]              tag_o
);

  localparam int ZW = 16 + FracBits;
  localparam int NormStages = 6;
  localparam logic signed [ZW-1:0] QuarterZ = ZW'(QuarterTurn) <<< FracBits;

  // Normalising shifter stages.
  logic                    nv_q  [NormStages+1];
  logic signed [NormW-1:0] nx_q  [NormStages+1];
  logic signed [NormW-1:0] ny_q  [NormStages+1];
  logic                    nz_q  [NormStages+1];
  logic [TagW-1:0]         nt_q  [NormStages+1];

  // Rotation stages.
  logic                   cv_q [Steps+1];
  logic signed [VecW-1:0] cx_q [Steps+1];
  logic signed [VecW-1:0] cy_q [Steps+1];
  logic signed [ZW-1:0]   cz_q [Steps+1];
  logic                   c0_q [Steps+1];
  logic [TagW-1:0]        ct_q [Steps+1];

  logic signed [VecW-1:0] qx, qy;

  // Input register with the zero-vector flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q[0] <= 1'b0;
    end else begin
      nv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q[0] <= NormW'(x_i);
    ny_q[0] <= NormW'(y_i);
    nz_q[0] <= (x_i == '0) && (y_i == '0);
    nt_q[0] <= tag_i;
  end

  // Greedy binary shift: take each power-of-two shift that keeps both inside 2^40.
  for (genvar k = 0; k < NormStages; k++) begin : g_norm
    localparam int Sh = 32 >> k;
    localparam logic signed [NormW-1:0] Lim = NormW'(1) <<< (40 - Sh);
    logic ok;

    assign ok = (nx_q[k] < Lim) && (nx_q[k] > -Lim) && (ny_q[k] < Lim) && (ny_q[k] > -Lim);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nv_q[k+1] <= 1'b0;
      end else begin
        nv_q[k+1] <= nv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      nx_q[k+1] <= ok ? (nx_q[k] <<< Sh) : nx_q[k];
      ny_q[k+1] <= ok ? (ny_q[k] <<< Sh) : ny_q[k];
      nz_q[k+1] <= nz_q[k];
      nt_q[k+1] <= nt_q[k];
    end
  end

  // Last doubling crosses 2^40; a left-half vector is turned by a quarter turn.
  assign qx = VecW'(nx_q[NormStages]) <<< 1;
  assign qy = VecW'(ny_q[NormStages]) <<< 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else begin
      cv_q[0] <= nv_q[NormStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (qx[VecW-1] && !qy[VecW-1]) begin
      cx_q[0] <= qy;
      cy_q[0] <= -qx;
      cz_q[0] <= QuarterZ;
    end else if (qx[VecW-1]) begin
      cx_q[0] <= -qy;
      cy_q[0] <= qx;
      cz_q[0] <= -QuarterZ;
    end else begin
      cx_q[0] <= qx;
      cy_q[0] <= qy;
      cz_q[0] <= '0;
    end
    c0_q[0] <= nz_q[NormStages];
    ct_q[0] <= nt_q[NormStages];
  end

  // One micro-rotation per stage, driving y towards zero.
  for (genvar i = 0; i < Steps; i++) begin : g_step
    localparam logic signed [ZW-1:0] Step = ZW'(atan_step(i, FracBits));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (!cy_q[i][VecW-1]) begin
        cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] + Step;
      end else begin
        cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
        cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
        cz_q[i+1] <= cz_q[i] - Step;
      end
      c0_q[i+1] <= c0_q[i];
      ct_q[i+1] <= ct_q[i];
    end
  end

  // A zero vector has angle zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cv_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    ang_o <= c0_q[Steps] ? '0 : cz_q[Steps];
    tag_o <= ct_q[Steps];
  end

endmodule

// ===== rtl/planar_three_link_inverse_kinematics_core.sv =====
// Top level of the planar three-link arm inverse kinematics core.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------------------
//  request  | start_i, busy_o        | target_x_i, target_y_i, pitch_i
//  result   | valid_o (one cycle)    | shoulder_angle_o, elbow_angle_o, wrist_angle_o,
//           |                        | reachable_o
//  config   | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// A new request can be taken in every cycle; each result passes through the two CORDIC
// pipelines and the 32-stage square root pipeline in series.
// Reset clears the pipeline and loads the default link lengths.
// The result side cannot stall, so the request queue never fills and busy_o stays low.
module planar_three_link_inverse_kinematics_core import ptlik_pkg::*; #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [LenW-1:0]          cfg_data_i,
  input  logic                     start_i,
  input  logic signed [CoordW-1:0] target_x_i,
  input  logic signed [CoordW-1:0] target_y_i,
  input  logic signed [PitchW-1:0] pitch_i,
  output logic                     busy_o,
  output logic                     valid_o,
  output logic signed [15:0]       shoulder_angle_o,
  output logic [13:0]              elbow_angle_o,
  output logic signed [16:0]       wrist_angle_o,
  output logic                     reachable_o
);

  localparam int ZW      = 16 + FRACTION_BITS;
  localparam int RotTagW = 2 * CoordW + PitchW;
  localparam int SqTagW  = 1 + PitchW + 32 + VinW + 19 + 19;
  localparam int VecTagW = 1 + PitchW;
  localparam logic signed [ZW:0] Half = (ZW+1)'(1) <<< (FRACTION_BITS - 1);

  // Configuration and values derived from it.
  logic [LenW-1:0]    l1_q, l2_q, l3_q;
  logic [15:0]        lsum_q;
  logic signed [15:0] ldif_q;
  logic [31:0]        sum_sq_q, dif_sq_q;
  logic [29:0]        l1sq_q, l2sq_q, lprod_q;
  logic [30:0]        lim_q, two_l1sq_q;
  logic [61:0]        lim_sq_q;

  // Front end and rotation.
  logic                   req_valid;
  req_t                   req;
  logic                   rot_valid;
  logic signed [CosW-1:0] rot_cos, rot_sin;
  logic [RotTagW-1:0]     rot_tag;

  // Geometry stages.
  logic                     s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic                     s5_valid_q, s6_valid_q, s7_valid_q, s8_valid_q;
  logic signed [48:0]       s1_pc_q, s1_ps_q;
  logic signed [CoordW-1:0] s1_x_q, s1_y_q;
  logic signed [PitchW-1:0] s1_p_q, s2_p_q, s3_p_q, s4_p_q, s5_p_q, s6_p_q, s7_p_q, s8_p_q;
  logic signed [18:0]       s2_xw_q, s2_yw_q, s3_xw_q, s3_yw_q, s4_xw_q, s4_yw_q;
  logic signed [18:0]       s5_xw_q, s5_yw_q, s6_xw_q, s6_yw_q, s7_xw_q, s7_yw_q;
  logic signed [18:0]       s8_xw_q, s8_yw_q;
  logic [35:0]              s3_xx_q, s3_yy_q;
  logic [36:0]              s4_d2_q;
  logic                     s5_reach_q, s6_reach_q, s7_reach_q, s8_reach_q;
  logic signed [38:0]       s5_num_q;
  logic signed [31:0]       s6_num_q, s7_num_q, s8_num_q;
  logic signed [VinW-1:0]   s7_a_q, s8_a_q;
  logic [61:0]              s7_nsq_q, s8_diff_q;
  logic signed [48:0]       pc_round, ps_round;
  logic signed [38:0]       lim_s;
  logic signed [63:0]       nsq_full;

  // Square root and angle units.
  logic                  sq_valid;
  logic [SqrtOutW-1:0]   sq_root;
  logic [SqTagW-1:0]     sq_tag;
  logic                  sq_reach;
  logic signed [PitchW-1:0] sq_p;
  logic signed [31:0]    sq_num;
  logic signed [VinW-1:0] sq_a;
  logic signed [18:0]    sq_xw, sq_yw;
  logic signed [VinW-1:0] sq_sn;
  logic                  v0_valid;
  logic signed [ZW-1:0]  v0_ang, v1_ang, v2_ang;
  logic [VecTagW-1:0]    v0_tag;

  // Result stages.
  logic                     f1_valid_q;
  logic signed [15:0]       f1_el_q;
  logic signed [16:0]       f1_sh_q;
  logic                     f1_reach_q;
  logic signed [PitchW-1:0] f1_p_q;
  logic signed [ZW:0]       el_sum, sh_sum;
  logic [13:0]              el_clamp;
  logic signed [18:0]       wrist;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= 15'd3072;
      l2_q <= 15'd2560;
      l3_q <= 15'd2048;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUpper: l1_q <= cfg_data_i;
        RegFore:  l2_q <= cfg_data_i;
        RegTool:  l3_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Link-length products, refreshed every cycle; they settle long before an item needs them.
  always_ff @(posedge clk_i) begin
    lsum_q     <= {1'b0, l1_q} + {1'b0, l2_q};
    ldif_q     <= $signed({1'b0, l1_q}) - $signed({1'b0, l2_q});
    sum_sq_q   <= lsum_q * lsum_q;
    dif_sq_q   <= 32'(32'(ldif_q) * 32'(ldif_q));
    l1sq_q     <= l1_q * l1_q;
    l2sq_q     <= l2_q * l2_q;
    lprod_q    <= l1_q * l2_q;
    lim_q      <= {lprod_q, 1'b0};
    two_l1sq_q <= {l1sq_q, 1'b0};
    lim_sq_q   <= {60'(lprod_q) * 60'(lprod_q), 2'b00};
  end

  ptlik_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .target_x_i  (target_x_i),
    .target_y_i  (target_y_i),
    .pitch_i     (pitch_i),
    .busy_o      (busy_o),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  ptlik_rot #(
    .Steps    (CORDIC_STEPS),
    .FracBits (FRACTION_BITS),
    .TagW     (RotTagW)
  ) u_rot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_valid),
    .ang_i   (req.ang),
    .neg_i   (req.neg),
    .tag_i   ({req.x, req.y, req.p}),
    .valid_o (rot_valid),
    .cos_o   (rot_cos),
    .sin_o   (rot_sin),
    .tag_o   (rot_tag)
  );

  // Valid chain of the geometry stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= rot_valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
    end
  end

  assign pc_round = s1_pc_q + 49'sd536870912;
  assign ps_round = s1_ps_q + 49'sd536870912;
  assign lim_s    = $signed({8'b0, lim_q});
  assign nsq_full = s6_num_q * s6_num_q;

  // Wrist point, squared distance, reach test, clamped cosine numerator and radicand.
  always_ff @(posedge clk_i) begin
    // Tool offset along the pitch.
    s1_pc_q <= $signed({1'b0, l3_q}) * rot_cos;
    s1_ps_q <= $signed({1'b0, l3_q}) * rot_sin;
    s1_x_q  <= $signed(rot_tag[RotTagW-1 -: CoordW]);
    s1_y_q  <= $signed(rot_tag[PitchW +: CoordW]);
    s1_p_q  <= $signed(rot_tag[PitchW-1:0]);
    // Step back from the tip to the wrist.
    s2_xw_q <= 19'(s1_x_q) - 19'(pc_round >>> UnitShift);
    s2_yw_q <= 19'(s1_y_q) - 19'(ps_round >>> UnitShift);
    s2_p_q  <= s1_p_q;
    // Squares of the wrist coordinates.
    s3_xx_q <= 36'(36'(s2_xw_q) * 36'(s2_xw_q));
    s3_yy_q <= 36'(36'(s2_yw_q) * 36'(s2_yw_q));
    s3_xw_q <= s2_xw_q;
    s3_yw_q <= s2_yw_q;
    s3_p_q  <= s2_p_q;
    // Squared wrist distance.
    s4_d2_q <= 37'(s3_xx_q) + 37'(s3_yy_q);
    s4_xw_q <= s3_xw_q;
    s4_yw_q <= s3_yw_q;
    s4_p_q  <= s3_p_q;
    // Reach annulus and law-of-cosines numerator.
    s5_reach_q <= (s4_d2_q <= 37'(sum_sq_q)) && (s4_d2_q >= 37'(dif_sq_q));
    s5_num_q   <= $signed({2'b0, s4_d2_q}) - $signed({9'b0, l1sq_q})
                  - $signed({9'b0, l2sq_q});
    s5_xw_q    <= s4_xw_q;
    s5_yw_q    <= s4_yw_q;
    s5_p_q     <= s4_p_q;
    // Cosine clamp to [-1, 1].
    if (s5_num_q > lim_s) begin
      s6_num_q <= 32'(lim_s);
    end else if (s5_num_q < -lim_s) begin
      s6_num_q <= 32'(-lim_s);
    end else begin
      s6_num_q <= 32'(s5_num_q);
    end
    s6_reach_q <= s5_reach_q;
    s6_xw_q    <= s5_xw_q;
    s6_yw_q    <= s5_yw_q;
    s6_p_q     <= s5_p_q;
    // Square of the numerator and the shoulder's second x term.
    s7_nsq_q   <= nsq_full[61:0];
    s7_a_q     <= $signed({3'b0, two_l1sq_q}) + VinW'(s6_num_q);
    s7_num_q   <= s6_num_q;
    s7_reach_q <= s6_reach_q;
    s7_xw_q    <= s6_xw_q;
    s7_yw_q    <= s6_yw_q;
    s7_p_q     <= s6_p_q;
    // Radicand for the sine term.
    s8_diff_q  <= lim_sq_q - s7_nsq_q;
    s8_a_q     <= s7_a_q;
    s8_num_q   <= s7_num_q;
    s8_reach_q <= s7_reach_q;
    s8_xw_q    <= s7_xw_q;
    s8_yw_q    <= s7_yw_q;
    s8_p_q     <= s7_p_q;
  end

  ptlik_isqrt #(
    .TagW (SqTagW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s8_valid_q),
    .rad_i   (s8_diff_q),
    .tag_i   ({s8_reach_q, s8_p_q, s8_num_q, s8_a_q, s8_xw_q, s8_yw_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  assign {sq_reach, sq_p, sq_num, sq_a, sq_xw, sq_yw} = sq_tag;
  assign sq_sn = $signed({2'b00, sq_root});

  // Elbow angle atan2(s, n).
  ptlik_vec #(
    .Steps    (CORDIC_STEPS),
    .FracBits (FRACTION_BITS),
    .TagW     (VecTagW)
  ) u_vec_elbow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .x_i     (VinW'(sq_num)),
    .y_i     (sq_sn),
    .tag_i   ({sq_reach, sq_p}),
    .valid_o (v0_valid),
    .ang_o   (v0_ang),
    .tag_o   (v0_tag)
  );

  // Direction of the wrist point.
  ptlik_vec #(
    .Steps    (CORDIC_STEPS),
    .FracBits (FRACTION_BITS),
    .TagW     (1)
  ) u_vec_wrist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .x_i     (VinW'(sq_xw)),
    .y_i     (VinW'(sq_yw)),
    .tag_i   (1'b0),
    .valid_o (),
    .ang_o   (v1_ang),
    .tag_o   ()
  );

  // Shoulder offset between the wrist direction and the upper link.
  ptlik_vec #(
    .Steps    (CORDIC_STEPS),
    .FracBits (FRACTION_BITS),
    .TagW     (1)
  ) u_vec_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .x_i     (sq_a),
    .y_i     (sq_sn),
    .tag_i   (1'b0),
    .valid_o (),
    .ang_o   (v2_ang),
    .tag_o   ()
  );

  // Round the angles half up to whole 1/64 degree.
  assign el_sum = (ZW+1)'(v0_ang) + Half;
  assign sh_sum = (ZW+1)'(v1_ang) + (ZW+1)'(v2_ang) + Half;

  // Clamp the elbow and let the wrist take up the rest of the pitch.
  always_comb begin
    if (f1_el_q < 16'sd0) begin
      el_clamp = '0;
    end else if (f1_el_q > 16'(HalfTurn)) begin
      el_clamp = 14'(HalfTurn);
    end else begin
      el_clamp = 14'(f1_el_q);
    end
    wrist = 19'(f1_p_q) - 19'(f1_sh_q) - $signed({5'b0, el_clamp});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      f1_valid_q <= v0_valid;
      valid_o    <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_el_q    <= 16'(el_sum >>> FRACTION_BITS);
    f1_sh_q    <= 17'(sh_sum >>> FRACTION_BITS);
    f1_reach_q <= v0_tag[VecTagW-1];
    f1_p_q     <= $signed(v0_tag[PitchW-1:0]);
    // Out of reach gives all-zero angles.
    shoulder_angle_o <= f1_reach_q ? f1_sh_q[15:0] : '0;
    elbow_angle_o    <= f1_reach_q ? el_clamp : '0;
    wrist_angle_o    <= f1_reach_q ? wrist[16:0] : '0;
    reachable_o      <= f1_reach_q;
  end

endmodule
